FILE: design/aavr_pkg.sv
// Package for the axis-angle vector rotator: formats, constants and the arctangent table.
package aavr_pkg;

    // Number of CORDIC steps, capped at the table length
    localparam int CORDIC_STEPS = 16;
    localparam int NSTEP        = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

    // Q4.30 constants
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic signed [33:0] Q30_PI      = 34'sd3373259426;
    localparam logic signed [33:0] Q30_HALF_PI = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    // CORDIC working word
    typedef logic signed [33:0] cw_t;

    // atan(2^-i) in Q.30, truncated
    function automatic cw_t atan_q30(input int idx);
        cw_t r;
        case (idx)
            0:       r = 34'sh03243F6A8;
            1:       r = 34'sh01DAC6705;
            2:       r = 34'sh00FADBAFC;
            3:       r = 34'sh007F56EA6;
            4:       r = 34'sh003FEAB76;
            5:       r = 34'sh001FFD55B;
            6:       r = 34'sh000FFFAAA;
            7:       r = 34'sh0007FFF55;
            8:       r = 34'sh0003FFFEA;
            9:       r = 34'sh0001FFFFD;
            10:      r = 34'sh0000FFFFF;
            11:      r = 34'sh00007FFFF;
            12:      r = 34'sh00003FFFF;
            13:      r = 34'sh00001FFFF;
            14:      r = 34'sh00000FFFF;
            15:      r = 34'sh000007FFF;
            16:      r = 34'sh000003FFF;
            17:      r = 34'sh000001FFF;
            18:      r = 34'sh000000FFF;
            19:      r = 34'sh0000007FF;
            20:      r = 34'sh0000003FF;
            21:      r = 34'sh0000001FF;
            22:      r = 34'sh0000000FF;
            23:      r = 34'sh00000007F;
            24:      r = 34'sh00000003F;
            25:      r = 34'sh00000001F;
            26:      r = 34'sh00000000F;
            27:      r = 34'sh000000008;
            28:      r = 34'sh000000004;
            29:      r = 34'sh000000002;
            30:      r = 34'sh000000001;
            default: r = 34'sh000000000;
        endcase
        return r;
    endfunction

endpackage

FILE: design/axis_angle_vector_rotator.sv
// Top level of the axis-angle vector rotator: CORDIC, Rodrigues matrix and product pipeline.
//
//  channel | direction | handshake         | words
//  --------+-----------+-------------------+-----------------------------------------------
//  in      | in        | in_valid/in_stall | vec_x/y/z Q16.16, axis_x/y/z Q2.14, angle Q3.13
//  out     | out       | out_valid/out_stall | out_x/y/z Q16.16 saturated
//
// One word enters per cycle while no held output word is stalled; there is one register
// per CORDIC step plus the angle reduction, matrix and product stages.
// Reset clears only the stage valid bits.
// A stall on the output freezes the whole pipeline and is passed straight to in_stall
// when the output register holds a word; nothing is dropped or repeated.
module axis_angle_vector_rotator
    import aavr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [15:0] angle,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z
);

    logic adv;

    // Advance the whole pipeline unless a held output word is stalled
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // CORDIC chain: index 0 is the reduced-angle stage, NSTEP the last step
    logic              v_reg    [0:NSTEP];
    cw_t               cx_reg   [0:NSTEP];
    cw_t               cy_reg   [0:NSTEP];
    cw_t               cz_reg   [0:NSTEP];
    logic              flip_reg [0:NSTEP];
    logic signed [31:0] vx_reg  [0:NSTEP];
    logic signed [31:0] vy_reg  [0:NSTEP];
    logic signed [31:0] vz_reg  [0:NSTEP];
    logic signed [15:0] ax_reg  [0:NSTEP];
    logic signed [15:0] ay_reg  [0:NSTEP];
    logic signed [15:0] az_reg  [0:NSTEP];

    cw_t  z_wide;
    cw_t  z0_next;
    logic flip0_next;

    // Widen angle to Q.30 and reduce by pi when beyond a right angle
    always_comb
    begin
        z_wide = cw_t'({{1{angle[15]}}, angle, 17'd0});
        if (z_wide > Q30_HALF_PI)
        begin
            z0_next    = z_wide - Q30_PI;
            flip0_next = 1'b1;
        end
        else if (z_wide < -Q30_HALF_PI)
        begin
            z0_next    = z_wide + Q30_PI;
            flip0_next = 1'b1;
        end
        else
        begin
            z0_next    = z_wide;
            flip0_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0]   <= CORDIC_GAIN;
            cy_reg[0]   <= '0;
            cz_reg[0]   <= z0_next;
            flip_reg[0] <= flip0_next;
            vx_reg[0]   <= vec_x;
            vy_reg[0]   <= vec_y;
            vz_reg[0]   <= vec_z;
            ax_reg[0]   <= axis_x;
            ay_reg[0]   <= axis_y;
            az_reg[0]   <= axis_z;
        end
    end

    // One micro-rotation per stage
    for (genvar k = 0; k < NSTEP; k++)
    begin : g_cordic
        cw_t cx_next, cy_next, cz_next;

        always_comb
        begin
            if (!cz_reg[k][33])
            begin
                cx_next = cx_reg[k] - (cy_reg[k] >>> k);
                cy_next = cy_reg[k] + (cx_reg[k] >>> k);
                cz_next = cz_reg[k] - atan_q30(k);
            end
            else
            begin
                cx_next = cx_reg[k] + (cy_reg[k] >>> k);
                cy_next = cy_reg[k] - (cx_reg[k] >>> k);
                cz_next = cz_reg[k] + atan_q30(k);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k+1] <= 1'b0;
            else if (adv)
                v_reg[k+1] <= v_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cx_reg[k+1]   <= cx_next;
                cy_reg[k+1]   <= cy_next;
                cz_reg[k+1]   <= cz_next;
                flip_reg[k+1] <= flip_reg[k];
                vx_reg[k+1]   <= vx_reg[k];
                vy_reg[k+1]   <= vy_reg[k];
                vz_reg[k+1]   <= vz_reg[k];
                ax_reg[k+1]   <= ax_reg[k];
                ay_reg[k+1]   <= ay_reg[k];
                az_reg[k+1]   <= az_reg[k];
            end
        end
    end

    // Stage M1: undo the pi reduction and form axis products
    logic               v1_reg;
    cw_t                c1_reg, s1_reg;
    logic signed [31:0] axx1_reg, ayy1_reg, azz1_reg, axy1_reg, axz1_reg, ayz1_reg;
    logic signed [31:0] vx1_reg, vy1_reg, vz1_reg;
    logic signed [15:0] ax1_reg, ay1_reg, az1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (adv)
            v1_reg <= v_reg[NSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg   <= flip_reg[NSTEP] ? -cx_reg[NSTEP] : cx_reg[NSTEP];
            s1_reg   <= flip_reg[NSTEP] ? -cy_reg[NSTEP] : cy_reg[NSTEP];
            axx1_reg <= ax_reg[NSTEP] * ax_reg[NSTEP];
            ayy1_reg <= ay_reg[NSTEP] * ay_reg[NSTEP];
            azz1_reg <= az_reg[NSTEP] * az_reg[NSTEP];
            axy1_reg <= ax_reg[NSTEP] * ay_reg[NSTEP];
            axz1_reg <= ax_reg[NSTEP] * az_reg[NSTEP];
            ayz1_reg <= ay_reg[NSTEP] * az_reg[NSTEP];
            vx1_reg  <= vx_reg[NSTEP];
            vy1_reg  <= vy_reg[NSTEP];
            vz1_reg  <= vz_reg[NSTEP];
            ax1_reg  <= ax_reg[NSTEP];
            ay1_reg  <= ay_reg[NSTEP];
            az1_reg  <= az_reg[NSTEP];
        end
    end

    // Stage M2: scale axis products by 1-cos and axis by sin
    logic               v2_reg;
    cw_t                c2_reg;
    logic signed [65:0] pxx2_reg, pyy2_reg, pzz2_reg, pxy2_reg, pxz2_reg, pyz2_reg;
    logic signed [49:0] sx2_reg, sy2_reg, sz2_reg;
    logic signed [31:0] vx2_reg, vy2_reg, vz2_reg;
    cw_t                omc;

    assign omc = Q30_ONE - c1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (adv)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg   <= c1_reg;
            pxx2_reg <= 66'(axx1_reg * omc);
            pyy2_reg <= 66'(ayy1_reg * omc);
            pzz2_reg <= 66'(azz1_reg * omc);
            pxy2_reg <= 66'(axy1_reg * omc);
            pxz2_reg <= 66'(axz1_reg * omc);
            pyz2_reg <= 66'(ayz1_reg * omc);
            sx2_reg  <= 50'(ax1_reg * s1_reg);
            sy2_reg  <= 50'(ay1_reg * s1_reg);
            sz2_reg  <= 50'(az1_reg * s1_reg);
            vx2_reg  <= vx1_reg;
            vy2_reg  <= vy1_reg;
            vz2_reg  <= vz1_reg;
        end
    end

    // Stage M3: round, assemble and clamp the nine matrix entries
    function automatic logic signed [38:0] rnd28(input logic signed [65:0] p);
        logic signed [66:0] t;
        t = 67'(p) + 67'sd134217728;
        return 39'(t >>> 28);
    endfunction

    function automatic logic signed [36:0] rnd14(input logic signed [49:0] p);
        logic signed [50:0] t;
        t = 51'(p) + 51'sd8192;
        return 37'(t >>> 14);
    endfunction

    function automatic logic signed [31:0] clamp1(input logic signed [40:0] e);
        logic signed [31:0] r;
        if (e > 41'sd1073741824)
            r = 32'sd1073741824;
        else if (e < -41'sd1073741824)
            r = -32'sd1073741824;
        else
            r = 32'(e);
        return r;
    endfunction

    logic               v3_reg;
    logic signed [31:0] m3_reg [0:2][0:2];
    logic signed [31:0] vx3_reg, vy3_reg, vz3_reg;
    logic signed [40:0] rxx, ryy, rzz, rxy, rxz, ryz, rsx, rsy, rsz, cc;

    always_comb
    begin
        rxx = 41'(rnd28(pxx2_reg));
        ryy = 41'(rnd28(pyy2_reg));
        rzz = 41'(rnd28(pzz2_reg));
        rxy = 41'(rnd28(pxy2_reg));
        rxz = 41'(rnd28(pxz2_reg));
        ryz = 41'(rnd28(pyz2_reg));
        rsx = 41'(rnd14(sx2_reg));
        rsy = 41'(rnd14(sy2_reg));
        rsz = 41'(rnd14(sz2_reg));
        cc  = 41'(c2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (adv)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m3_reg[0][0] <= clamp1(rxx + cc);
            m3_reg[0][1] <= clamp1(rxy - rsz);
            m3_reg[0][2] <= clamp1(rxz + rsy);
            m3_reg[1][0] <= clamp1(rxy + rsz);
            m3_reg[1][1] <= clamp1(ryy + cc);
            m3_reg[1][2] <= clamp1(ryz - rsx);
            m3_reg[2][0] <= clamp1(rxz - rsy);
            m3_reg[2][1] <= clamp1(ryz + rsx);
            m3_reg[2][2] <= clamp1(rzz + cc);
            vx3_reg      <= vx2_reg;
            vy3_reg      <= vy2_reg;
            vz3_reg      <= vz2_reg;
        end
    end

    // Stage M4: multiply each entry by its vector component
    logic               v4_reg;
    logic signed [63:0] q4_reg [0:2][0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (adv)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < 3; r++)
            begin
                q4_reg[r][0] <= m3_reg[r][0] * vx3_reg;
                q4_reg[r][1] <= m3_reg[r][1] * vy3_reg;
                q4_reg[r][2] <= m3_reg[r][2] * vz3_reg;
            end
        end
    end

    // Stage M5: sum rows, round to Q16.16 and saturate into the output register
    function automatic logic signed [31:0] row_out(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input logic signed [63:0] d);
        logic signed [66:0] acc;
        logic signed [36:0] sh;
        logic signed [31:0] r;
        acc = 67'(a) + 67'(b) + 67'(d) + 67'sd536870912;
        sh  = 37'(acc >>> 30);
        if (sh > 37'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (sh < -37'sd2147483648)
            r = 32'sh80000000;
        else
            r = 32'(sh);
        return r;
    endfunction

    logic               ov_reg;
    logic signed [31:0] ox_reg, oy_reg, oz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (adv)
            ov_reg <= v4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ox_reg <= row_out(q4_reg[0][0], q4_reg[0][1], q4_reg[0][2]);
            oy_reg <= row_out(q4_reg[1][0], q4_reg[1][1], q4_reg[1][2]);
            oz_reg <= row_out(q4_reg[2][0], q4_reg[2][1], q4_reg[2][2]);
        end
    end

    assign out_valid = ov_reg;
    assign out_x     = ox_reg;
    assign out_y     = oy_reg;
    assign out_z     = oz_reg;

endmodule

FILE: dv/axis_angle_vector_rotator_checker.sv
// Checker for the axis-angle vector rotator: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module axis_angle_vector_rotator_checker
    import aavr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic signed [15:0] angle,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic signed [31:0] out_x,
    input  logic signed [31:0] out_y,
    input  logic signed [31:0] out_z,
    output int                 fail_count,
    output int                 pending_words,
    output int                 checked_words
);

    typedef struct packed
    {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } rot_vec_t;

    rot_vec_t rotated_q[$];

    // atan(2^-i) in Q.30, truncated
    localparam longint ATAN_TBL [32] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F,
        64'h0000003F, 64'h0000001F, 64'h0000000F, 64'h00000008,
        64'h00000004, 64'h00000002, 64'h00000001, 64'h00000000
    };

    // round half up by n bits (>>> floors on signed longint)
    function automatic longint round_shift(longint v, int n);
        return (v + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic rot_vec_t rotate_vertex(longint vx, longint vy, longint vz,
                                               longint ax, longint ay, longint az,
                                               longint ang);
        longint z, x, y, nx, c, s, omc, acc;
        longint a [3];
        longint v [3];
        longint m [3][3];
        bit     flip;
        int     steps;
        rot_vec_t r;
        a = '{ax, ay, az};
        v = '{vx, vy, vz};
        // reduce angle into CORDIC range, then rotate
        z = ang * 131072;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        steps = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
        if (z > 64'sd1686629713)
        begin
            z = z - 64'sd3373259426;
            flip = 1'b1;
        end
        else if (z < -64'sd1686629713)
        begin
            z = z + 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < steps; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - ATAN_TBL[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + ATAN_TBL[i];
            end
            x = nx;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
        omc = 64'sd1073741824 - c;
        // build the rotation matrix
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                m[i][j] = round_shift(a[i] * a[j] * omc, 28);
        for (int i = 0; i < 3; i++)
            m[i][i] = m[i][i] + c;
        m[0][1] = m[0][1] - round_shift(a[2] * s, 14);
        m[1][0] = m[1][0] + round_shift(a[2] * s, 14);
        m[0][2] = m[0][2] + round_shift(a[1] * s, 14);
        m[2][0] = m[2][0] - round_shift(a[1] * s, 14);
        m[1][2] = m[1][2] - round_shift(a[0] * s, 14);
        m[2][1] = m[2][1] + round_shift(a[0] * s, 14);
        // apply to the vector and saturate
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int j = 0; j < 3; j++)
                acc = acc + limit(m[i][j], -64'sd1073741824, 64'sd1073741824) * v[j];
            acc = limit(round_shift(acc, 30), -64'sd2147483648, 64'sd2147483647);
            if (i == 0) r.x = acc[31:0];
            else if (i == 1) r.y = acc[31:0];
            else r.z = acc[31:0];
        end
        return r;
    endfunction

    assign pending_words = rotated_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        rot_vec_t e;
        if (!rst_n)
        begin
            fail_count    <= 0;
            checked_words <= 0;
        end
        else
        begin
            // predict each accepted input word
            if (in_valid && !in_stall)
                rotated_q.push_back(rotate_vertex(vec_x, vec_y, vec_z,
                                                  axis_x, axis_y, axis_z, angle));
            // compare each accepted output word
            if (out_valid && !out_stall)
            begin
                checked_words <= checked_words + 1;
                if (rotated_q.size() == 0)
                begin
                    $error("output word with nothing expected: %0d %0d %0d",
                           out_x, out_y, out_z);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = rotated_q.pop_front();
                    if (e.x !== out_x || e.y !== out_y || e.z !== out_z)
                    begin
                        if (e.x !== out_x)
                            $error("out_x expected %0d actual %0d", e.x, out_x);
                        if (e.y !== out_y)
                            $error("out_y expected %0d actual %0d", e.y, out_y);
                        if (e.z !== out_z)
                            $error("out_z expected %0d actual %0d", e.z, out_z);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

FILE: dv/axis_angle_vector_rotator_tb.sv
// Testbench top for the axis-angle vector rotator: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module axis_angle_vector_rotator_tb;
    import aavr_pkg::*;

    localparam int  RANDOM_WORDS = 850;
    localparam int  DRAIN_CYCLES = CORDIC_STEPS + 40;
    localparam longint CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] vec_x, vec_y, vec_z;
    logic signed [15:0] axis_x, axis_y, axis_z, angle;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] out_x, out_y, out_z;
    int                 fail_count;
    int                 pending_words;
    int                 checked_words;
    longint             cycle_count = 0;

    axis_angle_vector_rotator u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z)
    );

    axis_angle_vector_rotator_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
        .axis_x(axis_x), .axis_y(axis_y), .axis_z(axis_z), .angle(angle),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .fail_count(fail_count), .pending_words(pending_words),
        .checked_words(checked_words)
    );

    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // random gap length: mostly short, a few long, some runs with none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 25)
            out_stall <= ($urandom_range(0, 9) < 9) ? 1'b1 : 1'b0;
        else if ($urandom_range(0, 99) < 60)
            out_stall <= 1'b0;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAIL axis_angle_vector_rotator");
            $finish;
        end
    end

    // present one word and hold it until accepted
    task automatic send_word(logic signed [31:0] vx, logic signed [31:0] vy,
                             logic signed [31:0] vz, logic signed [15:0] ax,
                             logic signed [15:0] ay, logic signed [15:0] az,
                             logic signed [15:0] ang);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        vec_x <= vx; vec_y <= vy; vec_z <= vz;
        axis_x <= ax; axis_y <= ay; axis_z <= az;
        angle <= ang;
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic signed [31:0] rand_vec();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            1:       return $signed($urandom_range(0, 2000000)) - 1000000;
            default: return $urandom();
        endcase
    endfunction

    // axis component: mostly unit-ish, sometimes any 16-bit pattern
    function automatic logic signed [15:0] rand_axis();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom());
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    function automatic logic signed [15:0] rand_angle();
        if ($urandom_range(0, 9) == 0)
            return 16'($urandom());
        return 16'($signed($urandom_range(0, 51472)) - 25736);
    endfunction

    initial
    begin
        int s;
        logic signed [15:0] ax, ay, az;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        vec_x = '0; vec_y = '0; vec_z = '0;
        axis_x = '0; axis_y = '0; axis_z = '0; angle = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: identity, quarter turns, plus and minus pi, out-of-range angles
        send_word(32'sh00010000, 32'sh00020000, 32'sh00030000, 16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_word(32'sh00010000, 32'sh0, 32'sh0, 16'sd0, 16'sd0, 16'sd16384, 16'sd12868);
        send_word(32'sh00010000, 32'sh0, 32'sh0, 16'sd16384, 16'sd0, 16'sd0, -16'sd12868);
        send_word(32'sh00010000, 32'sh00010000, 32'sh0, 16'sd0, 16'sd16384, 16'sd0, 16'sd25736);
        send_word(32'sh00010000, 32'sh00010000, 32'sh0, 16'sd0, 16'sd0, -16'sd16384, -16'sd25736);
        send_word(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 16'sd9459, 16'sd9459, 16'sd9459, 16'sd5000);
        send_word(32'sh80000000, 32'sh80000000, 32'sh80000000, -16'sd9459, 16'sd9459, -16'sd9459, -16'sd5000);
        send_word(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 16'sd0, 16'sd16384, 16'sd0, 16'sd25736);
        send_word(32'sh12345678, -32'sh1234567, 32'sh0ABCDEF0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_word(32'sh12345678, -32'sh1234567, 32'sh0ABCDEF0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_word(32'sh0, 32'sh0, 32'sh0, 16'sh8000, 16'sh7FFF, 16'sd0, 16'sd1);
        send_word(-32'sd1, 32'sd1, -32'sd1, 16'sd16384, 16'sd0, 16'sd0, -16'sd1);
        send_word(32'sh40000000, 32'shC0000000, 32'sh0, 16'sd11585, 16'sd11585, 16'sd0, 16'sd12869);
        send_word(32'sh00008000, 32'shFFFF8000, 32'sh00000001, 16'sd0, -16'sd16384, 16'sd0, -16'sd12869);

        // random words
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            s = $urandom_range(0, 3);
            ax = rand_axis(); ay = rand_axis(); az = rand_axis();
            // some pure-axis rotations
            if (s == 0)
            begin
                ax = 16'sd0; ay = 16'sd0; az = 16'sd0;
                case ($urandom_range(0, 2))
                    0: ax = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                    1: ay = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                    default: az = $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
                endcase
            end
            send_word(rand_vec(), rand_vec(), rand_vec(), ax, ay, az, rand_angle());
        end
        in_valid <= 1'b0;

        // drain
        while (pending_words != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Rotated %0d vertices: directed axes and angle extremes, random vectors,",
                 checked_words);
        $display("axes and angles including out-of-range patterns, under random stalls.");
        if (fail_count == 0 && pending_words == 0)
            $display("PASS axis_angle_vector_rotator");
        else
            $display("FAIL axis_angle_vector_rotator");
        $finish;
    end

endmodule

FILE: sim.f
design/aavr_pkg.sv
design/axis_angle_vector_rotator.sv
dv/axis_angle_vector_rotator_checker.sv
dv/axis_angle_vector_rotator_tb.sv
